// ----- rtl/parabola_breakpoint_x_macros.svh -----
// ----------------------------------------------------------------------------
// Parabola breakpoint X - assertion macros
// Concurrent check helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARABOLA_BREAKPOINT_X_MACROS_SVH
`define PARABOLA_BREAKPOINT_X_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PBX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbx check failed");
// next-cycle implication
`define PBX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbx check failed");
`else
`define PBX_ASSERT_IMP(lbl, ante, cons)
`define PBX_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/pbx_pkg.sv -----
// ----------------------------------------------------------------------------
// Parabola breakpoint X - package
// Request/result types and status codes.
// ----------------------------------------------------------------------------
package pbx_pkg;

    localparam int COORD_BITS = 16;
    localparam int OUT_BITS   = 48;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sweep_y;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
    } req_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] break_x;
        logic        [1:0]          status;
    } rsp_t;

endpackage

// ----- rtl/parabola_breakpoint_x.sv -----
// ----------------------------------------------------------------------------
// Parabola breakpoint X
// Pipelined x of the meeting point of two parabolas sharing a directrix.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req           taken when start && !busy
//  result    done, result               one-cycle strobe, no backpressure
//
//  One request per cycle; busy is always low.
//  Pipe depth is set by the one-bit-per-stage square root (RW stages) and
//  the one-bit-per-stage restoring divider (NW stages).
//  Reset clears only the valid bits; payload registers are not reset.
//  Nothing in the pipe ever stalls.
// ----------------------------------------------------------------------------
`include "parabola_breakpoint_x_macros.svh"

module parabola_breakpoint_x #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pbx_pkg::req_t req,
    output logic          done,
    output pbx_pkg::rsp_t result
);

    localparam int C  = pbx_pkg::COORD_BITS;
    localparam int D  = C + 1;
    localparam int PW = 2 * C;
    localparam int SW = 2 * C + 1;
    localparam int MW = 4 * C + 2 + 2 * FRAC_BITS;
    localparam int RW = MW / 2;
    localparam int KW = 2 * C + 2 + FRAC_BITS;
    localparam int NW = KW + 1;
    localparam int QW = NW + 1;
    localparam int OW = pbx_pkg::OUT_BITS;
    localparam int XW = (QW > OW) ? QW : OW + 1;
    localparam int MDW = D + FRAC_BITS - 1;

    localparam logic [OW-1:0] SAT_HI = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] SAT_LO = {1'b1, {(OW-1){1'b0}}};

    typedef struct packed {
        logic signed [D-1:0] p1;
        logic signed [D-1:0] p2;
        logic signed [D-1:0] dh;
        logic signed [D-1:0] dk;
        logic signed [D-1:0] ax;
        logic signed [D-1:0] bx;
        logic signed [D-1:0] mid;
        logic [C-1:0]        a_abs;
        logic                a_neg;
        logic                same_y;
        logic                inv;
    } sta_t;

    typedef struct packed {
        logic [PW-1:0]         pp;
        logic [PW-1:0]         dh2;
        logic [PW-1:0]         dk2;
        logic signed [2*D-1:0] t1;
        logic signed [2*D-1:0] t2;
        logic signed [D-1:0]   mid;
        logic [C-1:0]          a_abs;
        logic                  a_neg;
        logic                  same_y;
        logic                  inv;
    } stb_t;

    typedef struct packed {
        logic [PW-1:0]        pp;
        logic [SW-1:0]        s;
        logic signed [KW-1:0] k;
        logic [C-1:0]         a;
        logic                 inv;
    } stc_t;

    typedef struct packed {
        logic [MW-1:0]        rad;
        logic [RW:0]          rem;
        logic [RW-1:0]        root;
        logic signed [KW-1:0] k;
        logic [C-1:0]         a;
        logic                 inv;
    } sq_t;

    typedef struct packed {
        logic [NW-1:0] uq;
        logic [C-1:0]  rem;
        logic [C-1:0]  a;
        logic          neg;
        logic          inv;
    } dv_t;

    // ---------------------------------------------------------------- stage A
    logic va_reg;
    sta_t sa_reg, sa_next;

    always_comb
    begin
        logic signed [D-1:0] sy, ay, by, a_diff;
        sy = {req.sweep_y[C-1], req.sweep_y};
        ay = {req.a_y[C-1], req.a_y};
        by = {req.b_y[C-1], req.b_y};
        sa_next.ax = {req.a_x[C-1], req.a_x};
        sa_next.bx = {req.b_x[C-1], req.b_x};
        sa_next.p1 = ay - sy;
        sa_next.p2 = by - sy;
        sa_next.dh = sa_next.ax - sa_next.bx;
        sa_next.dk = ay - by;
        sa_next.mid = sa_next.ax + sa_next.bx;
        a_diff = by - ay;
        sa_next.a_neg = a_diff[D-1];
        sa_next.a_abs = a_diff[D-1] ? C'(-a_diff) : a_diff[C-1:0];
        sa_next.same_y = (ay == by);
        sa_next.inv = !sa_next.same_y &&
                      ((sa_next.p1 < 0 && sa_next.p2 > 0) ||
                       (sa_next.p1 > 0 && sa_next.p2 < 0));
    end

    // ---------------------------------------------------------------- stage B
    logic vb_reg;
    stb_t sb_reg, sb_next;

    always_comb
    begin
        logic signed [2*D-1:0] m_pp, m_dh, m_dk;
        m_pp = sa_reg.p1 * sa_reg.p2;
        m_dh = sa_reg.dh * sa_reg.dh;
        m_dk = sa_reg.dk * sa_reg.dk;
        sb_next.pp = m_pp[PW-1:0];
        sb_next.dh2 = m_dh[PW-1:0];
        sb_next.dk2 = m_dk[PW-1:0];
        sb_next.t1 = sa_reg.p2 * sa_reg.ax;
        sb_next.t2 = sa_reg.p1 * sa_reg.bx;
        sb_next.mid = sa_reg.mid;
        sb_next.a_abs = sa_reg.a_abs;
        sb_next.a_neg = sa_reg.a_neg;
        sb_next.same_y = sa_reg.same_y;
        sb_next.inv = sa_reg.inv;
    end

    // ---------------------------------------------------------------- stage C
    logic vc_reg;
    stc_t sc_reg, sc_next;

    always_comb
    begin
        logic signed [2*D-1:0] kk;
        logic signed [MDW-1:0] kmid;
        kk = sb_reg.t1 - sb_reg.t2;
        if (sb_reg.a_neg)
        begin
            kk = -kk;
        end
        kmid = {sb_reg.mid, {(FRAC_BITS-1){1'b0}}};
        sc_next.s = {1'b0, sb_reg.dh2} + {1'b0, sb_reg.dk2};
        sc_next.inv = sb_reg.inv;
        // equal y and invalid requests bypass the root: radicand 0, divisor 1
        if (sb_reg.same_y)
        begin
            sc_next.pp = '0;
            sc_next.k = KW'(kmid);
            sc_next.a = C'(1);
        end
        else if (sb_reg.inv)
        begin
            sc_next.pp = '0;
            sc_next.k = '0;
            sc_next.a = C'(1);
        end
        else
        begin
            sc_next.pp = sb_reg.pp;
            sc_next.k = {kk, {FRAC_BITS{1'b0}}};
            sc_next.a = sb_reg.a_abs;
        end
    end

    // -------------------------------------------- stage D and square root
    logic [RW:0] sq_v_reg;
    sq_t         sq_reg [RW+1];
    sq_t         sq_d_next;

    always_comb
    begin
        logic [PW+SW-1:0] prod;
        prod = sc_reg.pp * sc_reg.s;
        sq_d_next.rad = {1'b0, prod, {(2*FRAC_BITS){1'b0}}};
        sq_d_next.rem = '0;
        sq_d_next.root = '0;
        sq_d_next.k = sc_reg.k;
        sq_d_next.a = sc_reg.a;
        sq_d_next.inv = sc_reg.inv;
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_d_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < RW; gi++)
        begin : g_sqrt
            sq_t sq_next;

            always_comb
            begin
                logic [RW+2:0] cur, trial, diff;
                cur = {sq_reg[gi].rem, sq_reg[gi].rad[MW-1:MW-2]};
                trial = {1'b0, sq_reg[gi].root, 2'b01};
                diff = cur - trial;
                sq_next = sq_reg[gi];
                sq_next.rad = {sq_reg[gi].rad[MW-3:0], 2'b00};
                if (cur >= trial)
                begin
                    sq_next.rem = diff[RW:0];
                    sq_next.root = {sq_reg[gi].root[RW-2:0], 1'b1};
                end
                else
                begin
                    sq_next.rem = cur[RW:0];
                    sq_next.root = {sq_reg[gi].root[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                sq_reg[gi+1] <= sq_next;
            end
        end
    endgenerate

    // ------------------------------------------ numerator and divider
    logic [NW:0] dv_v_reg;
    dv_t         dv_reg [NW+1];
    dv_t         dv_0_next;

    always_comb
    begin
        logic signed [NW-1:0] num;
        logic                 exact;
        exact = (sq_reg[RW].rem == '0);
        // smaller root; floor of the root is short by one when not exact
        num = NW'(sq_reg[RW].k) - NW'({1'b0, sq_reg[RW].root}) - NW'(!exact);
        dv_0_next.neg = num[NW-1];
        dv_0_next.uq = num[NW-1] ? NW'(-num) : NW'(num);
        dv_0_next.rem = '0;
        dv_0_next.a = sq_reg[RW].a;
        dv_0_next.inv = sq_reg[RW].inv;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= dv_0_next;
    end

    generate
        for (gi = 0; gi < NW; gi++)
        begin : g_div
            dv_t dv_next;

            always_comb
            begin
                logic [C:0] cur, diff;
                logic       ge;
                cur = {dv_reg[gi].rem, dv_reg[gi].uq[NW-1]};
                diff = cur - {1'b0, dv_reg[gi].a};
                ge = (cur >= {1'b0, dv_reg[gi].a});
                dv_next = dv_reg[gi];
                dv_next.uq = {dv_reg[gi].uq[NW-2:0], ge};
                dv_next.rem = ge ? diff[C-1:0] : cur[C-1:0];
            end

            always_ff @(posedge clk)
            begin
                dv_reg[gi+1] <= dv_next;
            end
        end
    endgenerate

    // ---------------------------------------------------- round and clamp
    logic          done_reg;
    pbx_pkg::rsp_t result_reg, result_next;

    always_comb
    begin
        logic signed [QW-1:0] q;
        logic signed [XW-1:0] qx;
        logic [QW-1:0]        mag;
        logic                 fits;
        mag = {1'b0, dv_reg[NW].uq} + QW'(dv_reg[NW].rem != '0);
        q = dv_reg[NW].neg ? -signed'(mag) : signed'({1'b0, dv_reg[NW].uq});
        qx = XW'(q);
        fits = (&qx[XW-1:OW-1]) || !(|qx[XW-1:OW-1]);
        if (dv_reg[NW].inv)
        begin
            result_next.break_x = '0;
            result_next.status = pbx_pkg::ST_INVALID;
        end
        else if (!fits)
        begin
            result_next.break_x = qx[XW-1] ? SAT_LO : SAT_HI;
            result_next.status = pbx_pkg::ST_SAT;
        end
        else
        begin
            result_next.break_x = qx[OW-1:0];
            result_next.status = pbx_pkg::ST_OK;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            sq_v_reg <= '0;
            dv_v_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            sq_v_reg <= {sq_v_reg[RW-1:0], vc_reg};
            dv_v_reg <= {dv_v_reg[NW-1:0], sq_v_reg[RW]};
            done_reg <= dv_v_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        sc_reg <= sc_next;
        result_reg <= result_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------- assertions
    logic out_inv;
    logic out_sat;

    assign out_inv = done && (result.status == pbx_pkg::ST_INVALID);
    assign out_sat = done && (result.status == pbx_pkg::ST_SAT);

    `PBX_ASSERT_IMP(a_inv_zero, out_inv, result.break_x == '0)
    `PBX_ASSERT_IMP(a_status_code, done, result.status <= pbx_pkg::ST_SAT)
    `PBX_ASSERT_IMP(a_sat_extreme, out_sat, result.break_x == SAT_HI || result.break_x == SAT_LO)
    `PBX_ASSERT_IMP(a_div_rem, dv_v_reg[NW], dv_reg[NW].rem < dv_reg[NW].a)
    `PBX_ASSERT_NXT(a_div_to_done, dv_v_reg[NW], done)

endmodule
